// ----- hw/rtl/diff_drive_odometry_macros.svh -----
// Assertion macros shared by the odometry checker.
// Each macro expects signals named clk and arst_n in the scope of use.
`ifndef DIFF_DRIVE_ODOMETRY_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define DDO_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("odometry check failed");

// Next-cycle implication, disabled while in reset.
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry check failed");

`endif

// ----- hw/rtl/ddo_pkg.sv -----
// Package for the odometry block: widths, constants, unit request types.
// No dependencies; the units and the top level use it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package ddo_pkg;

	// CORDIC iteration count, capped at the size of the arctangent table.
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_ITERS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int ITER_W = $clog2(CORDIC_ITERS);

	// Serial multiplier operand and product widths.
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int MUL_CNT_W = $clog2(MUL_W + 1);

	// Variance divider.
	localparam int DIV_W = 39;
	localparam int DIV_STEPS = 24;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
	localparam logic [DIV_W-1:0] VAR_DIVISOR = 39'd1600;
	localparam logic [DIV_W-1:0] VAR_SAT_LIM = 39'd26843545600;

	localparam logic [MUL_W-1:0] INV_PI_Q32 = 33'd1367130551;
	localparam logic signed [31:0] CORDIC_GAIN_Q28 = 32'sd163008219;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE, ST_M_WST, ST_M_D, ST_CORD1, ST_M_P, ST_M_PX, ST_M_PY,
		ST_M_VX, ST_M_SQX, ST_DIVX, ST_M_VY, ST_M_SQY, ST_DIVY,
		ST_M_TURN, ST_CORD2, ST_OUT
	} ddo_state_t;

	typedef struct packed {
		logic start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} ddo_mul_req_t;

	typedef struct packed {
		logic done;
		logic [PROD_W-1:0] product;
	} ddo_mul_rsp_t;

	typedef struct packed {
		logic start;
		logic [31:0] angle;
	} ddo_cordic_req_t;

	typedef struct packed {
		logic done;
		logic signed [31:0] cs;
		logic signed [31:0] sn;
	} ddo_cordic_rsp_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] num;
	} ddo_div_req_t;

	typedef struct packed {
		logic done;
		logic [23:0] quot;
	} ddo_div_rsp_t;

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic [29:0] atan_turn(input logic [4:0] idx);
		logic [29:0] r;
		case (idx)
			5'd0: r = 30'h20000000;
			5'd1: r = 30'h12E4051D;
			5'd2: r = 30'h09FB385B;
			5'd3: r = 30'h051111D4;
			5'd4: r = 30'h028B0D43;
			5'd5: r = 30'h0145D7E1;
			5'd6: r = 30'h00A2F61E;
			5'd7: r = 30'h00517C55;
			5'd8: r = 30'h0028BE53;
			5'd9: r = 30'h00145F2E;
			5'd10: r = 30'h000A2F98;
			5'd11: r = 30'h000517CC;
			5'd12: r = 30'h00028BE6;
			5'd13: r = 30'h000145F3;
			5'd14: r = 30'h0000A2F9;
			5'd15: r = 30'h0000517C;
			5'd16: r = 30'h000028BE;
			5'd17: r = 30'h0000145F;
			5'd18: r = 30'h00000A2F;
			5'd19: r = 30'h00000517;
			5'd20: r = 30'h0000028B;
			5'd21: r = 30'h00000145;
			5'd22: r = 30'h000000A2;
			5'd23: r = 30'h00000051;
			default: r = 30'h0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ddo_if.sv -----
// Valid/ready channel interfaces for sample words and pose words.
// Standalone; no package dependency.
`timescale 1ns / 1ps
`default_nettype none
interface ddo_sample_if;
	logic valid;
	logic ready;
	logic [15:0] step_time;
	logic signed [15:0] yaw_rate_a;
	logic signed [15:0] yaw_rate_b;
	logic signed [15:0] left_speed_a;
	logic signed [15:0] left_speed_b;
	logic signed [15:0] right_speed_a;
	logic signed [15:0] right_speed_b;

	modport source(output valid, step_time, yaw_rate_a, yaw_rate_b, left_speed_a,
		left_speed_b, right_speed_a, right_speed_b, input ready);
	modport sink(input valid, step_time, yaw_rate_a, yaw_rate_b, left_speed_a,
		left_speed_b, right_speed_a, right_speed_b, output ready);
endinterface

interface ddo_pose_if;
	logic valid;
	logic ready;
	logic signed [47:0] pos_x;
	logic signed [47:0] pos_y;
	logic [15:0] heading;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;
	logic signed [15:0] lin_speed;
	logic signed [15:0] turn_rate;
	logic [23:0] var_vx;
	logic [23:0] var_vy;
	logic [28:0] var_turn;

	modport source(output valid, pos_x, pos_y, heading, quat_z, quat_w, lin_speed,
		turn_rate, var_vx, var_vy, var_turn, input ready);
	modport sink(input valid, pos_x, pos_y, heading, quat_z, quat_w, lin_speed,
		turn_rate, var_vx, var_vy, var_turn, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/ddo_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on ddo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddo_mul (
	input wire logic clk,
	input wire logic arst_n,
	input wire ddo_pkg::ddo_mul_req_t req,
	output ddo_pkg::ddo_mul_rsp_t rsp
);
	logic busy_q;
	logic done_q;
	logic [ddo_pkg::MUL_CNT_W-1:0] cnt_q;
	logic [ddo_pkg::PROD_W-1:0] a_q;
	logic [ddo_pkg::MUL_W-1:0] b_q;
	logic [ddo_pkg::PROD_W-1:0] acc_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= ddo_pkg::MUL_CNT_W'(ddo_pkg::MUL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ddo_pkg::MUL_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Add the shifted multiplicand for each set multiplier bit, LSB first.
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= {{(ddo_pkg::PROD_W - ddo_pkg::MUL_W){1'b0}}, req.a};
			b_q <= req.b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[ddo_pkg::PROD_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[ddo_pkg::MUL_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.product = acc_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_cordic.sv -----
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on ddo_pkg for the arctangent table and iteration count.
`timescale 1ns / 1ps
`default_nettype none
module ddo_cordic (
	input wire logic clk,
	input wire logic arst_n,
	input wire ddo_pkg::ddo_cordic_req_t req,
	output ddo_pkg::ddo_cordic_rsp_t rsp
);
	logic busy_q;
	logic done_q;
	logic [ddo_pkg::ITER_W-1:0] i_q;
	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [33:0] z_q;
	logic flip_q;
	logic signed [33:0] z0;
	logic signed [33:0] atan_ext;

	// Quadrant fold: bring the angle within a quarter turn of zero.
	always_comb begin
		z0 = 34'(signed'(req.angle));
		if (z0 > 34'sh040000000) begin
			z0 = z0 - 34'sh080000000;
		end else if (z0 < -34'sh040000000) begin
			z0 = z0 + 34'sh080000000;
		end
	end

	assign atan_ext = signed'({4'b0, ddo_pkg::atan_turn(5'(i_q))});

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == ddo_pkg::ITER_W'(ddo_pkg::CORDIC_ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 1'b1;
				end
			end
		end
	end

	// Micro-rotation toward zero residual angle.
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= ddo_pkg::CORDIC_GAIN_Q28;
			y_q <= '0;
			z_q <= z0;
			flip_q <= (z0 != 34'(signed'(req.angle)));
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - (y_q >>> i_q);
				y_q <= y_q + (x_q >>> i_q);
				z_q <= z_q - atan_ext;
			end else begin
				x_q <= x_q + (y_q >>> i_q);
				y_q <= y_q - (x_q >>> i_q);
				z_q <= z_q + atan_ext;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.cs = flip_q ? -x_q : x_q;
	assign rsp.sn = flip_q ? -y_q : y_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_div.sv -----
// Restoring divider by the variance constant, one quotient bit per cycle,
// saturating to 24 bits. Depends on ddo_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ddo_div (
	input wire logic clk,
	input wire logic arst_n,
	input wire ddo_pkg::ddo_div_req_t req,
	output ddo_pkg::ddo_div_rsp_t rsp
);
	logic busy_q;
	logic done_q;
	logic [ddo_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [ddo_pkg::DIV_W-1:0] rem_q;
	logic [ddo_pkg::DIV_W-1:0] dv_q;
	logic [23:0] quot_q;
	logic sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= ddo_pkg::DIV_CNT_W'(ddo_pkg::DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ddo_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Compare and subtract the shifted divisor, quotient MSB first.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dv_q <= ddo_pkg::VAR_DIVISOR << (ddo_pkg::DIV_STEPS - 1);
			quot_q <= '0;
			sat_q <= (req.num >= ddo_pkg::VAR_SAT_LIM);
		end else if (busy_q) begin
			if (rem_q >= dv_q) begin
				rem_q <= rem_q - dv_q;
				quot_q <= {quot_q[22:0], 1'b1};
			end else begin
				quot_q <= {quot_q[22:0], 1'b0};
			end
			dv_q <= {1'b0, dv_q[ddo_pkg::DIV_W-1:1]};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = sat_q ? '1 : quot_q;
endmodule
`default_nettype wire

// ----- hw/rtl/diff_drive_odometry.sv -----
// Dead-reckoning odometry: one pose word per sample word.
// Each sample passes through ten serial multiplies, two CORDIC passes and two divides,
// the multiplies taking most of the time, before its pose word goes to the output register.
// A new sample is accepted only in the idle state, after that hand-over, so a pose word
// stalled in the output register holds the next one back.
// Reset: asynchronous, clears heading, position and all control state.
`timescale 1ns / 1ps
`default_nettype none
module diff_drive_odometry (
	input wire logic clk,
	input wire logic arst_n,
	ddo_sample_if.sink sample,
	ddo_pose_if.source pose
);
	ddo_pkg::ddo_state_t state_q, state_d;
	logic run_q;
	logic run_set, run_clr;

	ddo_pkg::ddo_mul_req_t mul_req;
	ddo_pkg::ddo_mul_rsp_t mul_rsp;
	ddo_pkg::ddo_cordic_req_t cor_req;
	ddo_pkg::ddo_cordic_rsp_t cor_rsp;
	ddo_pkg::ddo_div_req_t div_req;
	ddo_pkg::ddo_div_rsp_t div_rsp;

	// Sample registers and state.
	logic [15:0] st_q;
	logic signed [16:0] ysum_q;
	logic signed [17:0] s4_q;
	logic [15:0] head_q;
	logic signed [47:0] x_acc_q, y_acc_q;
	logic [15:0] d_q;
	logic [31:0] m1_q;
	logic [32:0] p_q;
	logic signed [31:0] c_q, s_q;
	logic [18:0] vel_q;
	logic [37:0] vel_sq_q;
	logic [23:0] vvx_q, vvy_q;
	logic [28:0] vturn_q;
	logic signed [15:0] qz_q, qw_q;
	logic out_valid_q;

	// Derived values.
	logic [16:0] ysum_abs;
	logic [17:0] s4_abs;
	logic [31:0] c_abs, s_abs;
	logic d_neg;
	logic [ddo_pkg::PROD_W-1:0] rnd_d, rnd_pos, rnd_vel;
	logic [15:0] d_mag;
	logic [33:0] pos_mag;
	logic signed [33:0] pos_inc;
	logic signed [48:0] pos_sum;
	logic signed [47:0] pos_new;
	logic [32:0] turn_sum;
	logic signed [15:0] qz_val, qw_val;
	logic signed [16:0] w_half;
	logic signed [15:0] turn_val;

	ddo_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	ddo_cordic u_cordic (.clk(clk), .arst_n(arst_n), .req(cor_req), .rsp(cor_rsp));
	ddo_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// Magnitudes and rounding of the unit results.
	always_comb begin
		ysum_abs = ysum_q[16] ? 17'(-ysum_q) : 17'(ysum_q);
		s4_abs = s4_q[17] ? 18'(-s4_q) : 18'(s4_q);
		c_abs = c_q[31] ? 32'(-c_q) : 32'(c_q);
		s_abs = s_q[31] ? 32'(-s_q) : 32'(s_q);
		// Turn rate is the negated yaw sum, so the increment is negative for a positive sum.
		d_neg = !ysum_q[16] && (ysum_q != 17'sd0);
		rnd_d = mul_rsp.product + (66'd1 << 46);
		d_mag = rnd_d[62:47];
		rnd_pos = mul_rsp.product + (66'd1 << 29);
		pos_mag = rnd_pos[63:30];
		rnd_vel = mul_rsp.product + (66'd1 << 27);
		turn_sum = mul_rsp.product[32:0] + 33'd8;
		w_half = 17'(-(18'(ysum_q)) >>> 1);
		turn_val = (w_half > 17'sd32767) ? 16'sd32767 : 16'(w_half);
	end

	// Position update with clamping at the 48-bit limits.
	always_comb begin
		if (state_q == ddo_pkg::ST_M_PX) begin
			pos_inc = (s4_q[17] ^ c_q[31]) ? -signed'(pos_mag) : signed'(pos_mag);
			pos_sum = 49'(x_acc_q) + 49'(pos_inc);
		end else begin
			pos_inc = (s4_q[17] ^ s_q[31]) ? -signed'(pos_mag) : signed'(pos_mag);
			pos_sum = 49'(y_acc_q) + 49'(pos_inc);
		end
		if (pos_sum[48] != pos_sum[47]) begin
			pos_new = pos_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			pos_new = pos_sum[47:0];
		end
	end

	// Quaternion rounding and saturation from the half-heading CORDIC.
	function automatic logic signed [15:0] quat_round(input logic signed [31:0] v);
		logic [31:0] mag;
		logic [31:0] r;
		logic [18:0] q;
		logic signed [15:0] res;
		mag = v[31] ? 32'(-v) : 32'(v);
		r = mag + 32'd4096;
		q = r[31:13];
		if (v[31]) begin
			res = (q > 19'd32768) ? -16'sd32768 : 16'(-signed'({1'b0, q}));
		end else begin
			res = (q > 19'd32767) ? 16'sd32767 : 16'(q);
		end
		return res;
	endfunction

	assign qz_val = quat_round(cor_rsp.sn);
	assign qw_val = quat_round(cor_rsp.cs);

	// Sequencer: next state and unit requests.
	always_comb begin
		state_d = state_q;
		run_set = 1'b0;
		run_clr = 1'b0;
		mul_req = '0;
		cor_req = '0;
		div_req = '0;
		case (state_q)
			ddo_pkg::ST_IDLE: begin
				if (sample.valid) begin
					state_d = ddo_pkg::ST_M_WST;
				end
			end
			ddo_pkg::ST_M_WST, ddo_pkg::ST_M_D, ddo_pkg::ST_M_P, ddo_pkg::ST_M_PX,
			ddo_pkg::ST_M_PY, ddo_pkg::ST_M_VX, ddo_pkg::ST_M_SQX, ddo_pkg::ST_M_VY,
			ddo_pkg::ST_M_SQY, ddo_pkg::ST_M_TURN: begin
				mul_req.start = !run_q;
				run_set = !run_q;
				case (state_q)
					ddo_pkg::ST_M_WST: begin
						mul_req.a = 33'(ysum_abs);
						mul_req.b = 33'(st_q);
					end
					ddo_pkg::ST_M_D: begin
						mul_req.a = 33'(m1_q);
						mul_req.b = ddo_pkg::INV_PI_Q32;
					end
					ddo_pkg::ST_M_P: begin
						mul_req.a = 33'(s4_abs);
						mul_req.b = 33'(st_q);
					end
					ddo_pkg::ST_M_PX: begin
						mul_req.a = p_q;
						mul_req.b = 33'(c_abs);
					end
					ddo_pkg::ST_M_PY: begin
						mul_req.a = p_q;
						mul_req.b = 33'(s_abs);
					end
					ddo_pkg::ST_M_VX: begin
						mul_req.a = 33'(s4_abs);
						mul_req.b = 33'(c_abs);
					end
					ddo_pkg::ST_M_VY: begin
						mul_req.a = 33'(s4_abs);
						mul_req.b = 33'(s_abs);
					end
					ddo_pkg::ST_M_SQX, ddo_pkg::ST_M_SQY: begin
						mul_req.a = 33'(vel_q);
						mul_req.b = 33'(vel_q);
					end
					default: begin
						mul_req.a = 33'(ysum_abs);
						mul_req.b = 33'(ysum_abs);
					end
				endcase
				if (run_q && mul_rsp.done) begin
					run_clr = 1'b1;
					case (state_q)
						ddo_pkg::ST_M_WST: state_d = ddo_pkg::ST_M_D;
						ddo_pkg::ST_M_D: state_d = ddo_pkg::ST_CORD1;
						ddo_pkg::ST_M_P: state_d = ddo_pkg::ST_M_PX;
						ddo_pkg::ST_M_PX: state_d = ddo_pkg::ST_M_PY;
						ddo_pkg::ST_M_PY: state_d = ddo_pkg::ST_M_VX;
						ddo_pkg::ST_M_VX: state_d = ddo_pkg::ST_M_SQX;
						ddo_pkg::ST_M_SQX: state_d = ddo_pkg::ST_DIVX;
						ddo_pkg::ST_M_VY: state_d = ddo_pkg::ST_M_SQY;
						ddo_pkg::ST_M_SQY: state_d = ddo_pkg::ST_DIVY;
						default: state_d = ddo_pkg::ST_CORD2;
					endcase
				end
			end
			ddo_pkg::ST_CORD1, ddo_pkg::ST_CORD2: begin
				cor_req.start = !run_q;
				run_set = !run_q;
				if (state_q == ddo_pkg::ST_CORD1) begin
					cor_req.angle = {head_q, 16'd0};
				end else begin
					cor_req.angle = {1'b0, head_q, 15'd0};
				end
				if (run_q && cor_rsp.done) begin
					run_clr = 1'b1;
					state_d = (state_q == ddo_pkg::ST_CORD1) ? ddo_pkg::ST_M_P : ddo_pkg::ST_OUT;
				end
			end
			ddo_pkg::ST_DIVX, ddo_pkg::ST_DIVY: begin
				div_req.start = !run_q;
				run_set = !run_q;
				div_req.num = 39'(vel_sq_q) + 39'd800;
				if (run_q && div_rsp.done) begin
					run_clr = 1'b1;
					state_d = (state_q == ddo_pkg::ST_DIVX) ? ddo_pkg::ST_M_VY : ddo_pkg::ST_M_TURN;
				end
			end
			ddo_pkg::ST_OUT: begin
				if (!out_valid_q || pose.ready) begin
					state_d = ddo_pkg::ST_IDLE;
				end
			end
			default: state_d = ddo_pkg::ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddo_pkg::ST_IDLE;
			run_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (run_set) begin
				run_q <= 1'b1;
			end else if (run_clr) begin
				run_q <= 1'b0;
			end
		end
	end

	// Odometry state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			x_acc_q <= '0;
			y_acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && pose.ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ddo_pkg::ST_OUT && (!out_valid_q || pose.ready)) begin
				out_valid_q <= 1'b1;
			end
			if (run_clr && state_q == ddo_pkg::ST_M_D) begin
				head_q <= head_q + (d_neg ? 16'(-d_mag) : d_mag);
			end
			if (run_clr && state_q == ddo_pkg::ST_CORD1) begin
				head_q <= head_q + d_q;
			end
			if (run_clr && state_q == ddo_pkg::ST_M_PX) begin
				x_acc_q <= pos_new;
			end
			if (run_clr && state_q == ddo_pkg::ST_M_PY) begin
				y_acc_q <= pos_new;
			end
		end
	end

	// Working registers for the current sample.
	always_ff @(posedge clk) begin
		if (state_q == ddo_pkg::ST_IDLE && sample.valid) begin
			st_q <= sample.step_time;
			ysum_q <= 17'(sample.yaw_rate_a) + 17'(sample.yaw_rate_b);
			s4_q <= 18'(sample.left_speed_a) + 18'(sample.left_speed_b)
				+ 18'(sample.right_speed_a) + 18'(sample.right_speed_b);
		end
		if (run_clr) begin
			case (state_q)
				ddo_pkg::ST_M_WST: m1_q <= mul_rsp.product[31:0];
				ddo_pkg::ST_M_D: d_q <= d_neg ? 16'(-d_mag) : d_mag;
				ddo_pkg::ST_CORD1: begin
					c_q <= cor_rsp.cs;
					s_q <= cor_rsp.sn;
				end
				ddo_pkg::ST_M_P: p_q <= mul_rsp.product[32:0];
				ddo_pkg::ST_M_VX, ddo_pkg::ST_M_VY: vel_q <= rnd_vel[46:28];
				ddo_pkg::ST_M_SQX, ddo_pkg::ST_M_SQY: vel_sq_q <= mul_rsp.product[37:0];
				ddo_pkg::ST_DIVX: vvx_q <= div_rsp.quot;
				ddo_pkg::ST_DIVY: vvy_q <= div_rsp.quot;
				ddo_pkg::ST_M_TURN: vturn_q <= turn_sum[32:4];
				ddo_pkg::ST_CORD2: begin
					qz_q <= qz_val;
					qw_q <= qw_val;
				end
				default: ;
			endcase
		end
	end

	// Output register: loaded when the pose word is handed over.
	always_ff @(posedge clk) begin
		if (state_q == ddo_pkg::ST_OUT && (!out_valid_q || pose.ready)) begin
			pose.pos_x <= x_acc_q;
			pose.pos_y <= y_acc_q;
			pose.heading <= head_q;
			pose.quat_z <= qz_q;
			pose.quat_w <= qw_q;
			pose.lin_speed <= s4_q[17:2];
			pose.turn_rate <= turn_val;
			pose.var_vx <= vvx_q;
			pose.var_vy <= vvy_q;
			pose.var_turn <= vturn_q;
		end
	end

	assign sample.ready = (state_q == ddo_pkg::ST_IDLE);
	assign pose.valid = out_valid_q;
endmodule
`default_nettype wire

// ----- hw/rtl/ddo_checker.sv -----
// Port-level checks for the odometry block, bound to the top level.
// Depends on diff_drive_odometry_macros.svh and diff_drive_odometry.
`timescale 1ns / 1ps
`default_nettype none
`include "diff_drive_odometry_macros.svh"
module ddo_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [47:0] out_pos_x,
	input wire logic [28:0] out_var_turn
);
	// A stalled pose word stays offered.
	`DDO_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	// A stalled pose word keeps its position.
	`DDO_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_pos_x))
	// One sample at a time: after an accept the input closes.
	`DDO_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
	// The turn variance never exceeds a sixteenth of the largest squared yaw sum.
	`DDO_ASSERT_IMPL(a_turn_var_range, out_valid, out_var_turn <= 29'h10000000)
endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(sample.valid),
	.in_ready(sample.ready),
	.out_valid(pose.valid),
	.out_ready(pose.ready),
	.out_pos_x(pose.pos_x),
	.out_var_turn(pose.var_turn)
);
`default_nettype wire

// ----- tb/ddo_pose_checker.sv -----
// Checker for the odometry block: watches the sample and pose channels,
// predicts each pose word from its own fixed-point model and compares.
// Depends on ddo_if (channel interfaces).
`timescale 1ns / 1ps
`default_nettype none
module ddo_pose_checker (
	input wire logic clk,
	input wire logic arst_n,
	ddo_sample_if.sink sample,
	ddo_pose_if.sink pose,
	output int errors,
	output int pending
);
	localparam int TRIG_STEPS = 16;
	localparam longint INV_PI = 64'sd1367130551;
	localparam longint GAIN = 64'sd163008219;
	localparam longint XY_MAX = 64'sd140737488355327;
	localparam longint XY_MIN = -64'sd140737488355328;

	typedef struct {
		logic signed [47:0] pos_x;
		logic signed [47:0] pos_y;
		logic [15:0] heading;
		logic signed [15:0] quat_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] lin_speed;
		logic signed [15:0] turn_rate;
		logic [23:0] var_vx;
		logic [23:0] var_vy;
		logic [28:0] var_turn;
	} pose_word_t;

	pose_word_t expected_poses[$];
	logic [15:0] heading_q;
	longint x_q;
	longint y_q;

	// Arctangents of 2^-i in units of 2^-32 turn.
	longint atan_lut[16] = '{
		64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
		64'h0000517C
	};

	// Product scaled down by 2^n, rounded half away from zero.
	function automatic longint scale_round(longint a, longint b, int n);
		bit neg;
		longint unsigned m;
		neg = (a < 0) != (b < 0);
		m = longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
		m = (m + (64'd1 << (n - 1))) >> n;
		return neg ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// Rotation-mode CORDIC on a 2^-32 turn angle, Q2.28 results.
	task automatic rotate(input logic [31:0] ang, output longint cs, output longint sn);
		longint z, x, y, nx;
		bit flip;
		z = longint'(ang);
		x = GAIN;
		y = 0;
		flip = 0;
		if (z >= 64'sh80000000) z -= 64'sh100000000;
		if (z > 64'sh40000000 || z < -64'sh40000000) begin
			flip = 1;
			z += z > 0 ? -64'sh80000000 : 64'sh80000000;
		end
		for (int i = 0; i < TRIG_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= atan_lut[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += atan_lut[i];
			end
			x = nx;
		end
		cs = flip ? -x : x;
		sn = flip ? -y : y;
	endtask

	function automatic logic [23:0] speed_variance(longint s4, longint trig);
		longint v;
		longint unsigned r;
		v = scale_round(s4, trig, 28);
		r = (longint'(v * v) + 800) / 1600;
		return r > 64'hFFFFFF ? 24'hFFFFFF : r[23:0];
	endfunction

	// Advance the dead-reckoning state by one sample word.
	task automatic predict_pose();
		longint st, ysum, w, s4, d, c, s, qc, qs;
		pose_word_t p;
		st = longint'(sample.step_time);
		ysum = longint'(sample.yaw_rate_a) + longint'(sample.yaw_rate_b);
		w = -ysum;
		s4 = longint'(sample.left_speed_a) + longint'(sample.left_speed_b)
			+ longint'(sample.right_speed_a) + longint'(sample.right_speed_b);
		d = scale_round(w * st, INV_PI, 47);
		heading_q = heading_q + d[15:0];
		rotate({heading_q, 16'h0}, c, s);
		x_q = clamp(x_q + scale_round(s4 * st, c, 30), XY_MIN, XY_MAX);
		y_q = clamp(y_q + scale_round(s4 * st, s, 30), XY_MIN, XY_MAX);
		heading_q = heading_q + d[15:0];
		rotate({1'b0, heading_q, 15'h0}, qc, qs);
		p.pos_x = x_q[47:0];
		p.pos_y = y_q[47:0];
		p.heading = heading_q;
		p.quat_z = 16'(clamp(scale_round(qs, 1, 13), -32768, 32767));
		p.quat_w = 16'(clamp(scale_round(qc, 1, 13), -32768, 32767));
		p.lin_speed = 16'(s4 >>> 2);
		p.turn_rate = 16'(clamp(w >>> 1, -32768, 32767));
		p.var_vx = speed_variance(s4, c);
		p.var_vy = speed_variance(s4, s);
		p.var_turn = 29'((ysum * ysum + 8) >>> 4);
		expected_poses.push_back(p);
	endtask

	task automatic check_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Predict on every accepted sample word, compare every accepted pose word.
	always @(posedge clk or negedge arst_n) begin
		pose_word_t e;
		if (!arst_n) begin
			heading_q = '0;
			x_q = 0;
			y_q = 0;
			expected_poses.delete();
			errors = 0;
		end else begin
			if (sample.valid && sample.ready) predict_pose();
			if (pose.valid && pose.ready) begin
				if (expected_poses.size() == 0) begin
					errors++;
					$display("%0t: pose word with none expected, pos_x %0d", $time,
						pose.pos_x);
				end else begin
					e = expected_poses.pop_front();
					check_field("pos_x", e.pos_x, pose.pos_x);
					check_field("pos_y", e.pos_y, pose.pos_y);
					check_field("heading", e.heading, pose.heading);
					check_field("quat_z", e.quat_z, pose.quat_z);
					check_field("quat_w", e.quat_w, pose.quat_w);
					check_field("lin_speed", e.lin_speed, pose.lin_speed);
					check_field("turn_rate", e.turn_rate, pose.turn_rate);
					check_field("var_vx", e.var_vx, pose.var_vx);
					check_field("var_vy", e.var_vy, pose.var_vy);
					check_field("var_turn", e.var_turn, pose.var_turn);
				end
			end
		end
		pending = expected_poses.size();
	end
endmodule
`default_nettype wire

// ----- tb/tb_diff_drive_odometry.sv -----
// Testbench top for the odometry block: drives sample words, stalls the pose
// side, and reports the verdict. Depends on ddo_if, the block and ddo_pose_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_diff_drive_odometry;
	localparam int RANDOM_WORDS = 500;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 0;
	logic arst_n = 0;
	int errors;
	int pending;
	int quiet_cycles = 0;
	bit stim_done = 0;
	bit calm = 0;
	bit hold_pose = 0;

	ddo_sample_if sample();
	ddo_pose_if pose();

	diff_drive_odometry dut (.clk(clk), .arst_n(arst_n), .sample(sample), .pose(pose));
	ddo_pose_checker checker_i (.clk(clk), .arst_n(arst_n), .sample(sample), .pose(pose),
		.errors(errors), .pending(pending));

	always #5 clk = ~clk;

	// Drive one sample word and hold it until accepted; idle cycles drop valid.
	task automatic send_word(input logic [15:0] st, input logic [15:0] ya,
		input logic [15:0] yb, input logic [15:0] la, input logic [15:0] lb,
		input logic [15:0] ra, input logic [15:0] rb);
		while (!calm && $urandom_range(99) < 31) begin
			sample.valid <= 0;
			@(negedge clk);
		end
		sample.valid <= 1;
		sample.step_time <= st;
		sample.yaw_rate_a <= ya;
		sample.yaw_rate_b <= yb;
		sample.left_speed_a <= la;
		sample.left_speed_b <= lb;
		sample.right_speed_a <= ra;
		sample.right_speed_b <= rb;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_speed();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed(16'($urandom_range(4000))) - 16'sd2000);
		endcase
	endfunction

	// Pose side: random stalls, plus a long hold while samples keep coming.
	always @(negedge clk) begin
		if (hold_pose) pose.ready <= 0;
		else pose.ready <= calm ? 1'b1 : ($urandom_range(99) >= 31);
	end

	initial begin
		sample.valid = 0;
		sample.step_time = 0;
		sample.yaw_rate_a = 0;
		sample.yaw_rate_b = 0;
		sample.left_speed_a = 0;
		sample.left_speed_b = 0;
		sample.right_speed_a = 0;
		sample.right_speed_b = 0;
		pose.ready = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: extremes, zero step, turn-rate overflow, wrap, saturation.
		send_word(0, 16'h1234, 16'h4321, 100, 200, 300, 400);
		send_word(16'hFFFF, 0, 0, 0, 0, 0, 0);
		send_word(16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_word(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_word(16'hFFFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_word(1, 16'h0001, 16'hFFFF, 1, 0, 0, 0);
		send_word(16'h8000, 16'h4000, 16'h0000, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		for (int i = 0; i < 8; i++)
			send_word(16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF,
				16'h7FFF);
		for (int i = 0; i < 6; i++)
			send_word(16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
				16'h7FFF);

		// Long pose stall while samples keep being offered.
		fork
			begin
				hold_pose = 1;
				repeat (3000) @(negedge clk);
				hold_pose = 0;
			end
			for (int i = 0; i < 4; i++)
				send_word(16'($urandom), rand_speed(), rand_speed(), rand_speed(),
					rand_speed(), rand_speed(), rand_speed());
		join

		// Random part, with a stretch of no idling in the middle.
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			calm = (i >= 200 && i < 260);
			send_word($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(700)),
				rand_speed(), rand_speed(), rand_speed(), rand_speed(), rand_speed(),
				rand_speed());
		end
		sample.valid <= 0;
		calm = 0;
		stim_done = 1;
	end

	// Watchdog and end of run.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ((sample.valid && sample.ready) || (pose.valid && pose.ready))
				quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
			if (stim_done && pending == 0) begin
				repeat (500) @(posedge clk);
				if (errors == 0 && pending == 0) $display("end of test: clean");
				else $display("end of test: mismatches");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/ddo_pkg.sv
hw/rtl/ddo_if.sv
hw/rtl/ddo_mul.sv
hw/rtl/ddo_cordic.sv
hw/rtl/ddo_div.sv
hw/rtl/diff_drive_odometry.sv
hw/rtl/ddo_checker.sv
tb/ddo_pose_checker.sv
tb/tb_diff_drive_odometry.sv
